// ===== hw/rtl/mamt_pkg.sv =====
// ----------------------------------------------------------------------------
// mamt_pkg
// Shared types, codes and defaults of the multi alarm match table.
// ----------------------------------------------------------------------------
package mamt_pkg;

  localparam int unsigned MAX_ALARMS_DEF = 16;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_ENABLE = 3'd2,
    CMD_RESET  = 3'd3,
    CMD_TICK   = 3'd4,
    CMD_QUERY  = 3'd5,
    CMD_READ   = 3'd6,
    CMD_NONE   = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_WRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic                enabled;
    logic                triggered;
    logic                rep_daily;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    ptr_idx;
    logic    ptr_clr;
    logic    ptr_inc;
    logic    mem_rd;
    logic    rd_next;
    logic    mem_wr;
    logic    wr_new;
    logic    count_inc;
    logic    count_dec;
    logic    capture;
    logic    set_status;
    status_e status;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic in_range;
    logic more;
    logic next_more;
  } stat_t;

endpackage

// ===== hw/rtl/mamt_if.sv =====
// ----------------------------------------------------------------------------
// mamt_if
// Request and response channels of the multi alarm match table.
// ----------------------------------------------------------------------------
interface mamt_req_if;
  logic                              valid;
  logic                              ready;
  logic [mamt_pkg::CMD_W-1:0]        command;
  logic [mamt_pkg::HOUR_W-1:0]       alarm_hour;
  logic [mamt_pkg::MINUTE_W-1:0]     alarm_minute;
  logic                              repeat_daily;
  logic [mamt_pkg::INDEX_W-1:0]      index;
  logic                              enable;
  logic [mamt_pkg::HOUR_W-1:0]       now_hour;
  logic [mamt_pkg::MINUTE_W-1:0]     now_minute;

  modport source (output valid, command, alarm_hour, alarm_minute, repeat_daily,
                  index, enable, now_hour, now_minute, input ready);
  modport sink   (input valid, command, alarm_hour, alarm_minute, repeat_daily,
                  index, enable, now_hour, now_minute, output ready);
endinterface

interface mamt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [mamt_pkg::STATUS_W-1:0]     status;
  logic                              found;
  logic [mamt_pkg::INDEX_W-1:0]      found_index;
  logic [mamt_pkg::COUNT_W-1:0]      alarm_count;
  logic [mamt_pkg::HOUR_W-1:0]       entry_hour;
  logic [mamt_pkg::MINUTE_W-1:0]     entry_minute;
  logic                              entry_enabled;
  logic                              entry_triggered;
  logic                              entry_repeat;

  modport source (output valid, status, found, found_index, alarm_count, entry_hour,
                  entry_minute, entry_enabled, entry_triggered, entry_repeat,
                  input ready);
  modport sink   (input valid, status, found, found_index, alarm_count, entry_hour,
                  entry_minute, entry_enabled, entry_triggered, entry_repeat,
                  output ready);
endinterface

// ===== hw/rtl/mamt_datapath.sv =====
// ----------------------------------------------------------------------------
// mamt_datapath
// Alarm memory, entry count, scan pointer and result registers.
// ----------------------------------------------------------------------------
module mamt_datapath #(
  parameter int unsigned MaxAlarms = mamt_pkg::MAX_ALARMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [mamt_pkg::CMD_W-1:0]        command_i,
  input  logic [mamt_pkg::HOUR_W-1:0]       alarm_hour_i,
  input  logic [mamt_pkg::MINUTE_W-1:0]     alarm_minute_i,
  input  logic                              repeat_daily_i,
  input  logic [mamt_pkg::INDEX_W-1:0]      index_i,
  input  logic                              enable_i,
  input  logic [mamt_pkg::HOUR_W-1:0]       now_hour_i,
  input  logic [mamt_pkg::MINUTE_W-1:0]     now_minute_i,
  input  mamt_pkg::ctrl_t                   ctrl_i,
  output mamt_pkg::stat_t                   stat_o,
  output logic [mamt_pkg::STATUS_W-1:0]     status_o,
  output logic                              found_o,
  output logic [mamt_pkg::INDEX_W-1:0]      found_index_o,
  output logic [mamt_pkg::COUNT_W-1:0]      alarm_count_o,
  output logic [mamt_pkg::HOUR_W-1:0]       entry_hour_o,
  output logic [mamt_pkg::MINUTE_W-1:0]     entry_minute_o,
  output logic                              entry_enabled_o,
  output logic                              entry_triggered_o,
  output logic                              entry_repeat_o
);

  localparam int unsigned AW = (MaxAlarms > 1) ? $clog2(MaxAlarms) : 1;
  localparam int unsigned CW = $clog2(MaxAlarms + 1);

  // Latched request fields.
  mamt_pkg::cmd_e                  cmd_q;
  logic [mamt_pkg::HOUR_W-1:0]     ah_q, nh_q;
  logic [mamt_pkg::MINUTE_W-1:0]   am_q, nm_q;
  logic                            rep_q, en_q;
  logic [mamt_pkg::INDEX_W-1:0]    idx_q;

  logic [CW-1:0]                   count_q;
  logic [CW-1:0]                   ptr_q;
  logic [CW:0]                     ptr_plus;

  mamt_pkg::entry_t                mem_q [MaxAlarms];
  mamt_pkg::entry_t                rdata_q;
  mamt_pkg::entry_t                wdata;
  mamt_pkg::entry_t                mod_word;
  logic [AW-1:0]                   raddr, waddr;
  logic                            match, hit;

  mamt_pkg::status_e               status_q;
  logic                            found_q;
  logic [mamt_pkg::INDEX_W-1:0]    fidx_q;
  mamt_pkg::entry_t                entry_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= mamt_pkg::cmd_e'(command_i);
      ah_q  <= alarm_hour_i;
      am_q  <= alarm_minute_i;
      rep_q <= repeat_daily_i;
      idx_q <= index_i;
      en_q  <= enable_i;
      nh_q  <= now_hour_i;
      nm_q  <= now_minute_i;
    end
  end

  assign ptr_plus = {1'b0, ptr_q} + (CW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      if (ctrl_i.count_inc) begin
        count_q <= count_q + CW'(1);
      end else if (ctrl_i.count_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (ctrl_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (ctrl_i.ptr_idx) begin
        ptr_q <= CW'(idx_q);
      end else if (ctrl_i.ptr_inc) begin
        ptr_q <= CW'(ptr_plus);
      end
    end
  end

  assign raddr = ctrl_i.rd_next ? AW'(ptr_plus) : AW'(ptr_q);
  assign waddr = ctrl_i.wr_new ? AW'(count_q) : AW'(ptr_q);

  assign match = (rdata_q.hour == nh_q) && (rdata_q.minute == nm_q);
  assign hit   = match && rdata_q.enabled && !rdata_q.triggered;

  // A remove copies the word unchanged; enable, reset and tick edit flags.
  always_comb begin
    mod_word = rdata_q;
    unique case (cmd_q)
      mamt_pkg::CMD_ENABLE: mod_word.enabled = en_q;
      mamt_pkg::CMD_RESET: begin
        mod_word.triggered = 1'b0;
        mod_word.enabled   = rdata_q.enabled & rdata_q.rep_daily;
      end
      mamt_pkg::CMD_TICK: mod_word.triggered =
          match & (rdata_q.triggered | rdata_q.enabled);
      default: mod_word = rdata_q;
    endcase
  end

  always_comb begin
    if (ctrl_i.wr_new) begin
      wdata = '{hour: ah_q, minute: am_q, enabled: 1'b1, triggered: 1'b0,
                rep_daily: rep_q};
    end else begin
      wdata = mod_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_wr) begin
      mem_q[waddr] <= wdata;
    end
    if (ctrl_i.mem_rd) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      status_q <= mamt_pkg::STAT_OK;
      found_q  <= 1'b0;
      fidx_q   <= '0;
      entry_q  <= '0;
    end else begin
      if (ctrl_i.set_status) begin
        status_q <= ctrl_i.status;
      end
      if (ctrl_i.capture) begin
        if (cmd_q == mamt_pkg::CMD_QUERY) begin
          if (hit && !found_q) begin
            found_q <= 1'b1;
            fidx_q  <= mamt_pkg::INDEX_W'(ptr_q);
          end
        end else begin
          entry_q <= rdata_q;
        end
      end
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.full      = (count_q == CW'(MaxAlarms));
  assign stat_o.in_range  = (32'(idx_q) < 32'(count_q));
  assign stat_o.more      = (ptr_q < count_q);
  assign stat_o.next_more = (ptr_plus < {1'b0, count_q});

  assign status_o          = status_q;
  assign found_o           = found_q;
  assign found_index_o     = fidx_q;
  assign alarm_count_o     = mamt_pkg::COUNT_W'(count_q);
  assign entry_hour_o      = entry_q.hour;
  assign entry_minute_o    = entry_q.minute;
  assign entry_enabled_o   = entry_q.enabled;
  assign entry_triggered_o = entry_q.triggered;
  assign entry_repeat_o    = entry_q.rep_daily;

endmodule

// ===== hw/rtl/mamt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mamt_ctrl
// Command sequencer: decodes an item and walks the table one entry at a time.
// ----------------------------------------------------------------------------
module mamt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  input  mamt_pkg::stat_t  stat_i,
  output mamt_pkg::ctrl_t  ctrl_o
);

  mamt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mamt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    ctrl_o.status = mamt_pkg::STAT_OK;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;

    unique case (state_q)
      mamt_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = mamt_pkg::S_DECODE;
        end
      end

      mamt_pkg::S_DECODE: begin
        state_d = mamt_pkg::S_DONE;
        unique case (stat_i.cmd)
          mamt_pkg::CMD_ADD: begin
            if (stat_i.full) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = mamt_pkg::STAT_FULL;
            end else begin
              ctrl_o.mem_wr    = 1'b1;
              ctrl_o.wr_new    = 1'b1;
              ctrl_o.count_inc = 1'b1;
            end
          end
          mamt_pkg::CMD_REMOVE, mamt_pkg::CMD_ENABLE,
          mamt_pkg::CMD_RESET, mamt_pkg::CMD_READ: begin
            if (stat_i.in_range) begin
              ctrl_o.ptr_idx = 1'b1;
              state_d        = mamt_pkg::S_READ;
            end else begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = mamt_pkg::STAT_RANGE;
            end
          end
          mamt_pkg::CMD_TICK, mamt_pkg::CMD_QUERY: begin
            ctrl_o.ptr_clr = 1'b1;
            state_d        = mamt_pkg::S_READ;
          end
          default: state_d = mamt_pkg::S_DONE;
        endcase
      end

      mamt_pkg::S_READ: begin
        unique case (stat_i.cmd)
          mamt_pkg::CMD_REMOVE: begin
            // Pull the following entry down, or drop the last slot when done.
            if (stat_i.next_more) begin
              ctrl_o.mem_rd  = 1'b1;
              ctrl_o.rd_next = 1'b1;
              state_d        = mamt_pkg::S_WRITE;
            end else begin
              ctrl_o.count_dec = 1'b1;
              state_d          = mamt_pkg::S_DONE;
            end
          end
          mamt_pkg::CMD_TICK, mamt_pkg::CMD_QUERY: begin
            if (stat_i.more) begin
              ctrl_o.mem_rd = 1'b1;
              state_d       = mamt_pkg::S_WRITE;
            end else begin
              state_d = mamt_pkg::S_DONE;
            end
          end
          default: begin
            ctrl_o.mem_rd = 1'b1;
            state_d       = mamt_pkg::S_WRITE;
          end
        endcase
      end

      mamt_pkg::S_WRITE: begin
        unique case (stat_i.cmd)
          mamt_pkg::CMD_REMOVE, mamt_pkg::CMD_TICK: begin
            ctrl_o.mem_wr  = 1'b1;
            ctrl_o.ptr_inc = 1'b1;
            state_d        = mamt_pkg::S_READ;
          end
          mamt_pkg::CMD_QUERY: begin
            ctrl_o.capture = 1'b1;
            ctrl_o.ptr_inc = 1'b1;
            state_d        = mamt_pkg::S_READ;
          end
          mamt_pkg::CMD_ENABLE, mamt_pkg::CMD_RESET: begin
            ctrl_o.mem_wr = 1'b1;
            state_d       = mamt_pkg::S_DONE;
          end
          default: begin
            ctrl_o.capture = 1'b1;
            state_d        = mamt_pkg::S_DONE;
          end
        endcase
      end

      mamt_pkg::S_DONE: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = mamt_pkg::S_IDLE;
        end
      end

      default: state_d = mamt_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/multi_alarm_match_table_top.sv =====
// ----------------------------------------------------------------------------
// multi_alarm_match_table_top
// Compacted alarm table with add, remove, enable, reset, tick, query and read.
// ----------------------------------------------------------------------------
// One command item is taken at a time and answered with exactly one response
// item; the next item is accepted once that response has been taken. The
// table sits in a single-port memory that a sequencer visits one entry at a
// time (read, then write back or compare). The memory needs no clearing
// pass after reset: only entries below the count are ever read.
module multi_alarm_match_table_top #(
  parameter int unsigned MAX_ALARMS = mamt_pkg::MAX_ALARMS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mamt_req_if.sink   req_i,
  mamt_rsp_if.source rsp_o
);

  mamt_pkg::ctrl_t ctrl;
  mamt_pkg::stat_t stat;

  mamt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  mamt_datapath #(
    .MaxAlarms (MAX_ALARMS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .command_i         (req_i.command),
    .alarm_hour_i      (req_i.alarm_hour),
    .alarm_minute_i    (req_i.alarm_minute),
    .repeat_daily_i    (req_i.repeat_daily),
    .index_i           (req_i.index),
    .enable_i          (req_i.enable),
    .now_hour_i        (req_i.now_hour),
    .now_minute_i      (req_i.now_minute),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .status_o          (rsp_o.status),
    .found_o           (rsp_o.found),
    .found_index_o     (rsp_o.found_index),
    .alarm_count_o     (rsp_o.alarm_count),
    .entry_hour_o      (rsp_o.entry_hour),
    .entry_minute_o    (rsp_o.entry_minute),
    .entry_enabled_o   (rsp_o.entry_enabled),
    .entry_triggered_o (rsp_o.entry_triggered),
    .entry_repeat_o    (rsp_o.entry_repeat)
  );

endmodule

// ===== hw/rtl/mamt_checker.sv =====
// ----------------------------------------------------------------------------
// mamt_checker
// Port-level checks of the multi alarm match table.
// ----------------------------------------------------------------------------
module mamt_checker #(
  parameter int unsigned MaxAlarms = mamt_pkg::MAX_ALARMS_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            req_ready_i,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input logic [mamt_pkg::STATUS_W-1:0]   status_i,
  input logic                            found_i,
  input logic [mamt_pkg::COUNT_W-1:0]    alarm_count_i,
  input logic [mamt_pkg::HOUR_W-1:0]     entry_hour_i,
  input logic                            entry_enabled_i
);

  localparam logic [mamt_pkg::COUNT_W-1:0] FullCount =
      mamt_pkg::COUNT_W'(MaxAlarms % 32);

  // Only one item is in the block at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
      rsp_valid_i |-> !req_ready_i)
    else $error("request accepted while a response is pending");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
      rsp_valid_i && (status_i == mamt_pkg::STAT_FULL) |-> alarm_count_i == FullCount)
    else $error("full status with a table that is not full");

  a_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
      rsp_valid_i && found_i |->
        (status_i == mamt_pkg::STAT_OK) && (entry_hour_i == '0) && !entry_enabled_i)
    else $error("query response carries error status or entry fields");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      rsp_valid_i && !rsp_ready_i |=>
        rsp_valid_i && $stable(status_i) && $stable(alarm_count_i) && $stable(found_i))
    else $error("stalled response changed");

endmodule

bind multi_alarm_match_table_top mamt_checker #(
  .MaxAlarms (MAX_ALARMS)
) u_mamt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .found_i         (rsp_o.found),
  .alarm_count_i   (rsp_o.alarm_count),
  .entry_hour_i    (rsp_o.entry_hour),
  .entry_enabled_i (rsp_o.entry_enabled)
);
